// ===== rtl/edbe_pkg.sv =====
// ----------------------------------------------------------------------------
// edbe_pkg
// shared constants for the elias delta bit encoder
// ----------------------------------------------------------------------------
package edbe_pkg;

  // width of the value field on the request channel
  localparam int IN_W     = 32;
  // width of one packed output byte
  localparam int BYTE_W   = 8;
  // most bits that stay pending between requests
  localparam int PEND_MAX = 7;
  // bits needed to count the pending bits
  localparam int PEND_W   = 3;

endpackage

// ===== rtl/edbe_in_if.sv =====
// ----------------------------------------------------------------------------
// edbe_in_if
// request channel: one value to encode and its end-of-list mark
// ----------------------------------------------------------------------------
interface edbe_in_if;
  import edbe_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] value;
  logic            final_value;

  modport source (output valid, output value, output final_value, input ready);
  modport sink   (input valid, input value, input final_value, output ready);

endinterface

// ===== rtl/edbe_out_if.sv =====
// ----------------------------------------------------------------------------
// edbe_out_if
// result channel: one packed code byte with its end marks
// ----------------------------------------------------------------------------
interface edbe_out_if;
  import edbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              run_end;
  logic              stream_end;

  modport source (output valid, output code_byte, output run_end, output stream_end,
                  input ready);
  modport sink   (input valid, input code_byte, input run_end, input stream_end,
                  output ready);

endinterface

// ===== rtl/edbe_front.sv =====
// ----------------------------------------------------------------------------
// edbe_front
// takes requests, finds the code lengths and builds the left-aligned code
// ----------------------------------------------------------------------------
module edbe_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  edbe_in_if.sink din,
  output logic                                               push_valid,
  input  logic                                               push_ready,
  output logic [2*($clog2(VALUE_WIDTH+1)-1)+VALUE_WIDTH-1:0] push_code,
  output logic [$clog2(2*($clog2(VALUE_WIDTH+1)-1)+VALUE_WIDTH+1)-1:0] push_len,
  output logic                                               push_final
);
  import edbe_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int LG_W   = $clog2(VW);
  localparam int LP_W   = $clog2(VW + 1);
  localparam int L2MAX  = LP_W - 1;
  localparam int L2_W   = $clog2(L2MAX + 1);
  localparam int CODE_W = 2 * L2MAX + VW;
  localparam int LEN_W  = $clog2(CODE_W + 1);

  logic            a_valid;
  logic [VW-1:0]   a_n;
  logic [LG_W-1:0] a_lg;
  logic [L2_W-1:0] a_lg2;
  logic            a_final;

  logic [VW-1:0]   n_c;
  logic [LG_W-1:0] lg_c;
  logic [LP_W-1:0] lp1_c;
  logic [L2_W-1:0] lg2_c;
  logic            take;

  logic [LP_W-1:0]   lp1_b;
  logic [CODE_W-1:0] rcode;
  logic [LEN_W-1:0]  len_b;

  assign din.ready = !a_valid || push_ready;
  assign take      = din.valid && din.ready;

  // zero codes as one
  always_comb begin
    n_c = din.value[VW-1:0];
    if (n_c == '0) begin
      n_c = VW'(1);
    end
  end

  // position of the leading one
  always_comb begin
    lg_c = '0;
    for (int i = 1; i < VW; i++) begin
      if (n_c[i]) begin
        lg_c = LG_W'(i);
      end
    end
  end

  always_comb begin
    lp1_c = LP_W'(lg_c) + LP_W'(1);
    lg2_c = '0;
    for (int i = 1; i < LP_W; i++) begin
      if (lp1_c[i]) begin
        lg2_c = L2_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (push_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_n     <= n_c;
      a_lg    <= lg_c;
      a_lg2   <= lg2_c;
      a_final <= din.final_value;
    end
  end

  // length prefix then the value without its leading one
  always_comb begin
    lp1_b = LP_W'(a_lg) + LP_W'(1);
    rcode = (CODE_W'(lp1_b) << a_lg) | CODE_W'(a_n ^ (VW'(1) << a_lg));
    len_b = LEN_W'({a_lg2, 1'b1}) + LEN_W'(a_lg);
  end

  assign push_valid = a_valid;
  assign push_code  = rcode << (LEN_W'(CODE_W) - len_b);
  assign push_len   = len_b;
  assign push_final = a_final;

endmodule

// ===== rtl/edbe_queue.sv =====
// ----------------------------------------------------------------------------
// edbe_queue
// small register queue between the front and back parts
// ----------------------------------------------------------------------------
module edbe_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_pop,
  output logic [DATA_W-1:0] rd_data
);
  import edbe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (fill != CNT_W'(DEPTH));
  assign rd_valid = (fill != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/edbe_back.sv =====
// ----------------------------------------------------------------------------
// edbe_back
// bit packer: merges codes behind the pending bits and emits bytes
// ----------------------------------------------------------------------------
module edbe_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic                                               q_valid,
  output logic                                               q_pop,
  input  logic [2*($clog2(VALUE_WIDTH+1)-1)+VALUE_WIDTH-1:0] q_code,
  input  logic [$clog2(2*($clog2(VALUE_WIDTH+1)-1)+VALUE_WIDTH+1)-1:0] q_len,
  input  logic                                               q_final,
  edbe_out_if.source dout
);
  import edbe_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int L2MAX  = $clog2(VW + 1) - 1;
  localparam int CODE_W = 2 * L2MAX + VW;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int ACC_W  = CODE_W + PEND_MAX;
  localparam int CNT_W  = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             flush;

  logic [ACC_W-1:0] acc_next;
  logic [CNT_W-1:0] cnt_next;
  logic             flush_next;

  logic             big;
  logic             emit_needed;
  logic             out_free;
  logic             emit_fire;
  logic [CNT_W-1:0] rem;
  logic             is_end;

  assign big         = (cnt >= CNT_W'(BYTE_W));
  assign emit_needed = big || (flush && (cnt != '0));
  assign out_free    = !dout.valid || dout.ready;
  assign emit_fire   = emit_needed && out_free;
  assign rem         = big ? (cnt - CNT_W'(BYTE_W)) : '0;
  // last byte of this request: fewer than a byte left and, on a flush, no bits left
  assign is_end      = (rem < CNT_W'(BYTE_W)) && !(flush && (rem != '0));
  assign q_pop       = q_valid && (!emit_needed || (emit_fire && is_end));

  always_comb begin
    acc_next   = acc;
    cnt_next   = cnt;
    flush_next = flush;
    if (emit_fire) begin
      acc_next = big ? (acc << BYTE_W) : '0;
      cnt_next = rem;
      if (is_end) begin
        flush_next = 1'b0;
      end
    end
    if (q_pop) begin
      acc_next   = acc_next | ({q_code, PEND_MAX'(0)} >> cnt_next[PEND_W-1:0]);
      cnt_next   = cnt_next + CNT_W'(q_len);
      flush_next = q_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      cnt   <= '0;
      flush <= 1'b0;
    end else begin
      acc   <= acc_next;
      cnt   <= cnt_next;
      flush <= flush_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (emit_fire) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      dout.code_byte  <= acc[ACC_W-1 -: BYTE_W];
      dout.run_end    <= is_end;
      dout.stream_end <= is_end && flush;
    end
  end

endmodule

// ===== rtl/elias_delta_bit_encoder_core.sv =====
// ----------------------------------------------------------------------------
// elias_delta_bit_encoder_core
// elias delta encoder that packs codes msb-first into a byte stream
// ----------------------------------------------------------------------------
// Each request carries one value (low VALUE_WIDTH bits used, zero coded as
// one) and appends its Elias delta code to a byte stream, first bit in bit 7
// of each byte. Up to seven bits stay pending between requests; a request
// with final_value set pads the partial byte with zeros and flushes it.
// run_end marks the last byte a request caused, stream_end the last byte of
// the list. Timing: a request is registered in the front stage before it
// reaches a two-entry queue; a request yields k bytes (k is 0 to 7, at most 6
// for non-final values), and the packer emits one byte per cycle while the
// byte channel is not stalled and loads the next code in the cycle of the
// previous request's last byte. The back part sets the sustained rate; the
// front part takes a new request every cycle while the queue has room.
module elias_delta_bit_encoder_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  edbe_in_if.sink     din,
  edbe_out_if.source  dout
);
  import edbe_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int L2MAX  = $clog2(VW + 1) - 1;
  // longest code: prefix zeros, length field, value without leading one
  localparam int CODE_W = 2 * L2MAX + VW;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  // queue entry: left-aligned code, its length, final mark
  localparam int ENT_W  = CODE_W + LEN_W + 1;

  // front to queue
  logic              push_valid;
  logic              push_ready;
  logic [CODE_W-1:0] push_code;
  logic [LEN_W-1:0]  push_len;
  logic              push_final;

  // queue to back
  logic              q_valid;
  logic              q_pop;
  logic [ENT_W-1:0]  q_data;
  logic [CODE_W-1:0] q_code;
  logic [LEN_W-1:0]  q_len;
  logic              q_final;

  // front: zero fix, leading-one search, code assembly
  edbe_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_code  (push_code),
    .push_len   (push_len),
    .push_final (push_final)
  );

  // queue decouples code building from byte emission
  edbe_queue #(
    .DATA_W (ENT_W),
    .DEPTH  (2)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_code, push_len, push_final}),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_data)
  );

  assign q_code  = q_data[ENT_W-1 -: CODE_W];
  assign q_len   = q_data[LEN_W:1];
  assign q_final = q_data[0];

  // back: pending bits, byte emission, output register
  edbe_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_code  (q_code),
    .q_len   (q_len),
    .q_final (q_final),
    .dout    (dout)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the elias delta bit encoder core
// ----------------------------------------------------------------------------
// Requests are queued by an initial block and driven at the falling edge with
// random gaps. Random stalls are applied on the byte channel. At each
// accepted request the bench computes the delta code bits itself and queues
// the bytes they complete. Each accepted byte is checked field by field
// against the oldest queued byte.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edbe_pkg::*;

  // generous ceiling on the run, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400_000;
  // quiet cycles after the last owed byte has arrived
  localparam int TAIL_CYCLES = 40;
  // random part of the stimulus
  localparam int RANDOM_REQS = 246;

  // one request waiting to be driven
  typedef struct {
    logic [IN_W-1:0] value;
    logic            final_value;
    bit              drain;  // hold off until every owed byte has come
  } value_req_t;

  // one byte the encoder owes us
  typedef struct packed {
    logic [BYTE_W-1:0] code_byte;
    logic              run_end;
    logic              stream_end;
  } coded_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  edbe_in_if  req_ch ();
  edbe_out_if byte_ch ();

  elias_delta_bit_encoder_core #(
    .VALUE_WIDTH(IN_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .din (req_ch),
    .dout(byte_ch)
  );

  always #5 clk = ~clk;

  value_req_t  value_reqs[$];
  coded_byte_t owed_bytes[$];

  // bench copy of the bits still waiting for a full byte
  logic [PEND_MAX-1:0] held_bits = '0;
  int unsigned         held_count = 0;

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned reqs_total = 0;
  int unsigned reqs_taken = 0;
  bit          req_taken = 1'b0;     // request accepted at the last rising edge
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] byte check failed: %s", $time, what);
  endtask

  // stretches with no idling on either side, idling elsewhere
  function automatic bit calm_window();
    return (cycles % 1500) < 300;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_window() || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random bit length so that short and long codes both show up often
  function automatic logic [IN_W-1:0] pick_value();
    int unsigned     len;
    logic [IN_W-1:0] v;
    len = $urandom_range(0, IN_W);
    v   = $urandom;
    if (len == 0) return '0;
    if (len == IN_W) return v;
    return (v & ((IN_W'(1) << len) - 1)) | (IN_W'(1) << (len - 1));
  endfunction

  task automatic add_req(input logic [IN_W-1:0] value, input logic last, input bit drain);
    value_req_t r;
    r.value       = value;
    r.final_value = last;
    r.drain       = drain;
    value_reqs.push_back(r);
    reqs_total++;
  endtask

  // --------------------------------------------------------------------------
  // code prediction: appends the delta code of one value to the held bits
  // and queues every byte that becomes complete
  // --------------------------------------------------------------------------
  task automatic predict_bytes(input logic [IN_W-1:0] raw, input logic last);
    logic [IN_W-1:0] n;
    logic [63:0]     acc;
    int unsigned     cnt;
    int unsigned     lg;
    int unsigned     len_plus1;
    int unsigned     lg2;
    coded_byte_t     burst[$];
    coded_byte_t     b;
    // zero is coded as if it were one
    n  = (raw == '0) ? IN_W'(1) : raw;
    lg = 0;
    for (int i = 0; i < IN_W; i++) begin
      if (n[i]) lg = i;
    end
    len_plus1 = lg + 1;
    lg2 = 0;
    while ((len_plus1 >> (lg2 + 1)) != 0) lg2++;

    acc = 64'(held_bits);
    cnt = held_count;
    // lg2 zeros, then lg2+1 bits of L+1, then the low L bits of n
    acc = acc << lg2;
    cnt += lg2;
    acc = (acc << (lg2 + 1)) | 64'(len_plus1);
    cnt += lg2 + 1;
    acc = (acc << lg) | (64'(n) & ((64'd1 << lg) - 1));
    cnt += lg;

    while (cnt >= 8) begin
      b.code_byte  = 8'(acc >> (cnt - 8));
      b.run_end    = 1'b0;
      b.stream_end = 1'b0;
      burst.push_back(b);
      cnt -= 8;
    end
    acc &= (64'd1 << cnt) - 1;

    // last value of the list: pad the partial byte with zeros
    if (last && cnt > 0) begin
      b.code_byte  = 8'(acc << (8 - cnt));
      b.run_end    = 1'b0;
      b.stream_end = 1'b0;
      burst.push_back(b);
      cnt = 0;
      acc = '0;
    end

    if (burst.size() > 0) begin
      burst[burst.size() - 1].run_end    = 1'b1;
      burst[burst.size() - 1].stream_end = last;
    end
    foreach (burst[i]) owed_bytes.push_back(burst[i]);

    held_bits  = PEND_MAX'(acc);
    held_count = cnt;
  endtask

  // --------------------------------------------------------------------------
  // request driver: presents items from value_reqs at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid       <= 1'b0;
      req_ch.value       <= '0;
      req_ch.final_value <= 1'b0;
      gap_left = 0;
    end else if (req_ch.valid && !req_taken) begin
      // request still waiting for ready, hold it
    end else if (gap_left > 0) begin
      req_ch.valid <= 1'b0;
      gap_left--;
    end else if (value_reqs.size() > 0 &&
                 !(value_reqs[0].drain && owed_bytes.size() != 0)) begin
      req_ch.valid       <= 1'b1;
      req_ch.value       <= value_reqs[0].value;
      req_ch.final_value <= value_reqs[0].final_value;
      void'(value_reqs.pop_front());
      // idle time that follows once this request is taken
      gap_left = pick_gap();
    end else begin
      // nothing left, or a drain point waiting for the byte queue to empty
      req_ch.valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // byte sink: random back pressure at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      byte_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      byte_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      byte_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predicts on accepted requests, checks accepted bytes
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    coded_byte_t want;
    cycles++;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      req_taken = (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
      // predict first, so the byte queue is current before any check
      if (req_taken) begin
        predict_bytes(req_ch.value, req_ch.final_value);
        reqs_taken++;
      end
      if ((byte_ch.valid === 1'b1) && (byte_ch.ready === 1'b1)) begin
        if (owed_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", byte_ch.code_byte));
        end else begin
          want = owed_bytes.pop_front();
          if (byte_ch.code_byte !== want.code_byte)
            report_mismatch($sformatf("code_byte %02h, want %02h",
                                      byte_ch.code_byte, want.code_byte));
          if (byte_ch.run_end !== want.run_end)
            report_mismatch($sformatf("run_end %b, want %b on byte %02h",
                                      byte_ch.run_end, want.run_end, want.code_byte));
          if (byte_ch.stream_end !== want.stream_end)
            report_mismatch($sformatf("stream_end %b, want %b on byte %02h",
                                      byte_ch.stream_end, want.stream_end,
                                      want.code_byte));
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycles, owed_bytes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    // zero alone as a whole list: coded as one, padded to a single byte
    add_req(32'd0, 1'b1, 1'b0);
    // 8-bit code on an empty store: final without a pad byte
    add_req(32'd8, 1'b1, 1'b0);
    // short codes that produce nothing, then a final that fills one byte
    add_req(32'd1, 1'b0, 1'b0);
    add_req(32'd1, 1'b0, 1'b0);
    add_req(32'd1, 1'b0, 1'b0);
    add_req(32'd2, 1'b0, 1'b0);
    add_req(32'd1, 1'b1, 1'b0);
    // longest code, then a run across the edges of the bit lengths
    add_req(32'hffff_ffff, 1'b0, 1'b0);
    add_req(32'h8000_0000, 1'b0, 1'b0);
    add_req(32'h7fff_ffff, 1'b0, 1'b0);
    add_req(32'd65535, 1'b0, 1'b0);
    add_req(32'd65536, 1'b0, 1'b0);
    add_req(32'd255, 1'b0, 1'b0);
    add_req(32'd256, 1'b0, 1'b0);
    add_req(32'd3, 1'b0, 1'b0);
    add_req(32'd4, 1'b0, 1'b0);
    add_req(32'd7, 1'b0, 1'b0);
    add_req(32'd15, 1'b0, 1'b0);
    add_req(32'd16, 1'b1, 1'b0);
    // seven bits left over plus the longest code, flushed: most bytes per request
    add_req(32'd2, 1'b0, 1'b0);
    add_req(32'd1, 1'b0, 1'b0);
    add_req(32'd0, 1'b0, 1'b0);
    add_req(32'd0, 1'b0, 1'b0);
    add_req(32'hffff_ffff, 1'b1, 1'b0);

    // random part, with a few points where the sender waits for a full drain
    for (int i = 0; i < RANDOM_REQS; i++) begin
      add_req(pick_value(), ($urandom_range(0, 9) == 0), (i % 90 == 0));
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (reqs_taken != reqs_total) @(posedge clk);
    while (owed_bytes.size() != 0) @(posedge clk);
    // give the block time to show any stray byte
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/edbe_pkg.sv
rtl/edbe_in_if.sv
rtl/edbe_out_if.sv
rtl/edbe_front.sv
rtl/edbe_queue.sv
rtl/edbe_back.sv
rtl/elias_delta_bit_encoder_core.sv
tb/tb.sv
